### rtl/core/min_axis_distance_mst_weight_defines.svh
// Assertion macros shared by the min-axis MST weight block.
`ifndef MIN_AXIS_DISTANCE_MST_WEIGHT_DEFINES_SVH
`define MIN_AXIS_DISTANCE_MST_WEIGHT_DEFINES_SVH
// Same-cycle implication, checked outside reset.
`define MAD_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication failed");
// Next-cycle implication, checked outside reset.
`define MAD_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`endif

### rtl/core/mad_pkg.sv
// Types and constants of the min-axis MST weight block.
`timescale 1ns / 1ps
package mad_pkg;
	localparam int MAX_POINTS = 1024;
	localparam int COORD_BITS = 30;
	localparam int PTR_W = $clog2(MAX_POINTS);
	localparam int CNT_W = PTR_W + 1;
	localparam int WEIGHT_W = 31;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

	typedef struct packed {
		logic [COORD_BITS-1:0] coord_x;
		logic [COORD_BITS-1:0] coord_y;
		logic                  last_point;
	} point_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] tree_weight;
		logic                overflow_flag;
	} result_t;

	typedef enum logic [2:0] {
		S_LOAD, S_SETUP, S_SCAN, S_DRAIN1, S_DRAIN2, S_ACCUM, S_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic start_pass;
		logic step;
		logic end_pass;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic more_rounds;
	} status_t;
endpackage

### rtl/core/mad_ctrl.sv
// Controller state machine of the min-axis MST weight block.
`timescale 1ns / 1ps
module mad_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pt_valid,
	input  logic            last_point,
	output logic            pt_stall,
	input  logic            res_valid,
	input  logic            res_stall,
	input  mad_pkg::status_t st,
	output mad_pkg::cmd_t    cmd
);
	import mad_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		pt_stall = 1'b1;
		case (state_q)
			S_LOAD: begin
				pt_stall = 1'b0;
				if (pt_valid) begin
					cmd.load = 1'b1;
					if (last_point) state_d = S_SETUP;
				end
			end
			S_SETUP: begin
				if (st.more_rounds) begin
					cmd.start_pass = 1'b1;
					state_d = S_SCAN;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_SCAN: begin
				cmd.step = 1'b1;
				if (st.scan_last) state_d = S_DRAIN1;
			end
			S_DRAIN1: state_d = S_DRAIN2;
			S_DRAIN2: state_d = S_ACCUM;
			S_ACCUM: begin
				cmd.end_pass = 1'b1;
				state_d = S_SETUP;
			end
			S_EMIT: begin
				if (!res_valid || !res_stall) begin
					cmd.emit = 1'b1;
					state_d = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end
endmodule

### rtl/core/mad_datapath.sv
// Point stores, distance store and the Prim scan pipeline.
`timescale 1ns / 1ps
module mad_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  mad_pkg::cmd_t    cmd,
	input  mad_pkg::point_t  pt,
	output mad_pkg::status_t st,
	output mad_pkg::result_t res,
	output logic             res_valid,
	input  logic             res_stall
);
	import mad_pkg::*;

	logic [COORD_BITS-1:0] x_mem [MAX_POINTS];
	logic [COORD_BITS-1:0] y_mem [MAX_POINTS];
	// Each entry: in-tree mark above the current distance to the tree.
	logic [COORD_BITS:0]   d_mem [MAX_POINTS];

	logic [CNT_W-1:0]      count_q, rounds_q;
	logic                  ovf_q, first_q;
	logic [WEIGHT_W-1:0]   sum_q;
	logic [PTR_W-1:0]      v_q, cur_q, best_idx_q;
	logic [COORD_BITS-1:0] cur_x_q, cur_y_q, best_x_q, best_y_q, best_d_q;
	logic                  best_ok_q;
	logic                  full;

	logic [COORD_BITS-1:0] x_s1, y_s1, x_s2, y_s2, cost_s2, d_s2;
	logic [COORD_BITS:0]   d_s1;
	logic [PTR_W-1:0]      v_s1, v_s2;
	logic                  vld_s1, vld_s2, f_s2;
	logic [COORD_BITS-1:0] dx, dy, nd;
	logic                  fw;
	logic [WEIGHT_W:0]     sum_add;

	assign full = (count_q == CNT_W'(MAX_POINTS));
	assign st.scan_last = ({1'b0, v_q} == count_q - CNT_W'(1));
	assign st.more_rounds = (rounds_q + CNT_W'(1) < count_q);

	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			x_mem[count_q[PTR_W-1:0]] <= pt.coord_x;
			y_mem[count_q[PTR_W-1:0]] <= pt.coord_y;
		end
		x_s1 <= x_mem[v_q];
		y_s1 <= y_mem[v_q];
		d_s1 <= d_mem[v_q];
		if (vld_s2) d_mem[v_s2] <= {fw, nd};
	end

	// Stage 1: min-axis cost from the newest tree vertex.
	always_comb begin
		dx = (x_s1 >= cur_x_q) ? x_s1 - cur_x_q : cur_x_q - x_s1;
		dy = (y_s1 >= cur_y_q) ? y_s1 - cur_y_q : cur_y_q - y_s1;
	end

	always_ff @(posedge clk) begin
		v_s1 <= v_q;
		cost_s2 <= (dx < dy) ? dx : dy;
		d_s2 <= d_s1[COORD_BITS-1:0];
		f_s2 <= d_s1[COORD_BITS];
		x_s2 <= x_s1;
		y_s2 <= y_s1;
		v_s2 <= v_s1;
	end

	// Stage 2: relax the distance and keep the nearest outside vertex.
	always_comb begin
		nd = (first_q || cost_s2 < d_s2) ? cost_s2 : d_s2;
		fw = (v_s2 == cur_q) || (f_s2 && !first_q);
	end

	assign sum_add = {1'b0, sum_q} + {{(WEIGHT_W + 1 - COORD_BITS){1'b0}}, best_d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rounds_q <= '0;
			ovf_q <= 1'b0;
			first_q <= 1'b1;
			sum_q <= '0;
			v_q <= '0;
			cur_q <= '0;
			best_ok_q <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			vld_s1 <= cmd.step;
			vld_s2 <= vld_s1;
			if (res_valid && !res_stall) res_valid <= 1'b0;
			if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.start_pass) begin
				v_q <= '0;
				best_ok_q <= 1'b0;
			end
			if (cmd.step) v_q <= v_q + PTR_W'(1);
			if (vld_s2 && !fw && (!best_ok_q || nd < best_d_q)) best_ok_q <= 1'b1;
			if (cmd.end_pass) begin
				sum_q <= (sum_add > {1'b0, WEIGHT_MAX}) ? WEIGHT_MAX : sum_add[WEIGHT_W-1:0];
				cur_q <= best_idx_q;
				rounds_q <= rounds_q + CNT_W'(1);
				first_q <= 1'b0;
			end
			if (cmd.emit) begin
				res_valid <= 1'b1;
				count_q <= '0;
				rounds_q <= '0;
				ovf_q <= 1'b0;
				first_q <= 1'b1;
				sum_q <= '0;
				cur_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && count_q == '0) begin
			cur_x_q <= pt.coord_x;
			cur_y_q <= pt.coord_y;
		end else if (cmd.end_pass) begin
			cur_x_q <= best_x_q;
			cur_y_q <= best_y_q;
		end
		if (vld_s2 && !fw && (!best_ok_q || nd < best_d_q)) begin
			best_d_q <= nd;
			best_idx_q <= v_s2;
			best_x_q <= x_s2;
			best_y_q <= y_s2;
		end
		if (cmd.emit) begin
			res.tree_weight <= sum_q;
			res.overflow_flag <= ovf_q;
		end
	end
endmodule

### rtl/core/min_axis_distance_mst_weight.sv
// Top level of the min-axis distance MST weight block.
//   channel | valid     | stall     | payload
//   points  | pt_valid  | pt_stall  | pt_data  (mad_pkg::point_t)
//   result  | res_valid | res_stall | res_data (mad_pkg::result_t)
// Points load one beat per cycle into the point stores while pt_stall is low. After
// the beat marked last_point the block runs Prim's method over all pairs: n-1
// passes over the distance store, each scanning every stored vertex through
// the single read port of the stores. During that work pt_stall is high.
// Reset clears the count, weight and control state; the stores need no clear.
// A waiting result beat holds while the next set loads; a set that ends
// before it is taken waits with its own result.
`timescale 1ns / 1ps
module min_axis_distance_mst_weight (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pt_valid,
	output logic             pt_stall,
	input  mad_pkg::point_t  pt_data,
	output logic             res_valid,
	input  logic             res_stall,
	output mad_pkg::result_t res_data
);
	import mad_pkg::*;
	`include "min_axis_distance_mst_weight_defines.svh"

	// Commands flow from the controller; status flows back.
	cmd_t    cmd;
	status_t st;

	mad_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.pt_valid   (pt_valid),
		.last_point (pt_data.last_point),
		.pt_stall   (pt_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.st         (st),
		.cmd        (cmd)
	);

	mad_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.pt        (pt_data),
		.st        (st),
		.res       (res_data),
		.res_valid (res_valid),
		.res_stall (res_stall)
	);

	// A result beat appears right after it is committed.
	`MAD_NEXT(a_emit_shows, cmd.emit, res_valid)
	// A pass closes exactly when its last read has cleared the pipeline.
	`MAD_IMPLIES(a_pass_drained, cmd.end_pass, $past(cmd.step, 3) && !$past(cmd.step, 1))
	// The scan stops after the final vertex of the set.
	`MAD_NEXT(a_scan_stops, cmd.step && st.scan_last, !cmd.step)
endmodule
